// ===== hdl/dpsc_pkg.sv =====
package dpsc_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int MV_W      = 12;
  localparam int TRAVEL_W  = 10;
  localparam int REG_W     = 13;
  localparam int REG_IDX_W = 2;

  // Converter scaling: mv = floor(raw * 3300 / 4095).
  localparam int ADC_FULL_CODE = 4095;
  localparam int ADC_REF_MV    = 3300;
  localparam int PROD_W        = SAMPLE_W + MV_W;
  // 2^24 / 4095 is just above 4097, so (p * 4097) >> 24 undershoots by at most one.
  localparam int ADC_SHIFT     = 2 * SAMPLE_W;

  // Deadzone: d = floor(span / 20), estimated as (span * 3277) >> 16 and corrected.
  localparam int DZ_DIV   = 20;
  localparam int DZ_RECIP = 3277;
  localparam int DZ_SHIFT = 16;
  localparam int DZ_W     = 9;
  localparam int DZP_W    = REG_W + DZ_SHIFT - 4;

  // Plausibility limits.
  localparam int CH1_FLOOR_MV   = 500;
  localparam int CH2_FLOOR_MV   = 250;
  localparam int CH1_CEIL_MV    = 4500;
  localparam int CH2_CEIL_MV    = 2250;
  localparam int MIN_SPLIT_MV   = 30;
  localparam int MAX_TRAVEL_GAP = 100;
  localparam int CAL_MARGIN_MV  = 100;
  localparam int FULL_TRAVEL    = 1000;

  // Travel divider: quotient below 1024, one quotient bit per stage.
  localparam int DIV_STEPS = TRAVEL_W;
  localparam int NUM_W     = MV_W + TRAVEL_W;
  localparam int DEN_W     = REG_W;

  // Three lane setup stages, the divider, the lane output and the merge stage.
  localparam int PIPE_DEPTH = 3 + DIV_STEPS + 2;

  localparam logic [REG_W-1:0] CH1_MIN_RESET = 13'd600;
  localparam logic [REG_W-1:0] CH1_MAX_RESET = 13'd4400;
  localparam logic [REG_W-1:0] CH2_MIN_RESET = 13'd350;
  localparam logic [REG_W-1:0] CH2_MAX_RESET = 13'd2150;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_CH1_MIN = 2'd0,
    REG_CH1_MAX = 2'd1,
    REG_CH2_MIN = 2'd2,
    REG_CH2_MAX = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_one;
    logic [SAMPLE_W-1:0] sample_two;
  } sample_t;

  typedef struct packed {
    logic [MV_W-1:0]     volts_one_mv;
    logic [MV_W-1:0]     volts_two_mv;
    logic [TRAVEL_W-1:0] travel_one;
    logic [TRAVEL_W-1:0] travel_two;
    logic [TRAVEL_W-1:0] pedal_travel;
    logic                plausible;
  } result_t;

  typedef struct packed {
    logic [REG_W-1:0] min_mv;
    logic [REG_W-1:0] max_mv;
  } cal_t;

  typedef struct packed {
    logic [MV_W-1:0]     mv;
    logic [TRAVEL_W-1:0] travel;
  } lane_out_t;

endpackage

// ===== hdl/dpsc_lane.sv =====
module dpsc_lane (
  input  logic                           clk,
  input  logic                           en,
  input  logic [dpsc_pkg::SAMPLE_W-1:0]  raw,
  input  dpsc_pkg::cal_t                 cal,
  output dpsc_pkg::lane_out_t            lane_out
);
  import dpsc_pkg::*;

  typedef struct packed {
    logic [NUM_W-1:0]    rem;
    logic [TRAVEL_W-1:0] quo;
    logic [DEN_W-1:0]    den;
    logic [MV_W-1:0]     mv;
    logic                full;
    logic                pos;
  } div_stage_t;

  // Stage 1: scaling product and calibration span.
  logic [PROD_W-1:0] prod;
  logic [REG_W-1:0]  span;
  logic [REG_W-1:0]  span_next;
  logic [DZP_W-1:0]  span_prod;

  // Stage 2: millivolts and trimmed end points.
  logic [PROD_W+12:0]        scaled;
  logic [MV_W-1:0]           q_est;
  logic [PROD_W-1:0]         adc_rem;
  logic [MV_W-1:0]           mv_next;
  logic [DZ_W-1:0]           dz_est;
  logic [REG_W-1:0]          dz_times;
  logic [DZ_W-1:0]           dz;
  logic [MV_W-1:0]           mv2;
  logic [REG_W:0]            lo2;
  logic signed [REG_W+1:0]   hi2;

  // Stage 3 feeds the divider.
  logic                      full3;
  logic                      pos3;
  logic [MV_W-1:0]           offs3;
  logic signed [REG_W+1:0]   den_full;

  div_stage_t st [0:DIV_STEPS];

  assign span_next = (cal.max_mv >= cal.min_mv) ? (cal.max_mv - cal.min_mv)
                                                : (cal.min_mv - cal.max_mv);

  always_ff @(posedge clk) begin
    if (en) begin
      prod      <= {{(PROD_W-SAMPLE_W){1'b0}}, raw} * PROD_W'(ADC_REF_MV);
      span      <= span_next;
      span_prod <= {{(DZP_W-REG_W){1'b0}}, span_next} * DZP_W'(DZ_RECIP);
    end
  end

  always_comb begin
    scaled   = {13'd0, prod} + {1'b0, prod, 12'd0};
    q_est    = scaled[ADC_SHIFT+MV_W-1:ADC_SHIFT];
    adc_rem  = prod - (PROD_W'({q_est, 12'd0}) - PROD_W'(q_est));
    mv_next  = (adc_rem >= PROD_W'(ADC_FULL_CODE)) ? (q_est + 1'b1) : q_est;
    dz_est   = span_prod[DZ_SHIFT+DZ_W-1:DZ_SHIFT];
    dz_times = REG_W'({dz_est, 4'b0}) + REG_W'({dz_est, 2'b0});
    dz       = (dz_times > span) ? (dz_est - 1'b1) : dz_est;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mv2 <= mv_next;
      lo2 <= {1'b0, cal.min_mv} + (REG_W+1)'(dz);
      hi2 <= $signed({2'b0, cal.max_mv}) - $signed({{(REG_W+2-DZ_W){1'b0}}, dz});
    end
  end

  // The divider result is only used when lo < mv < hi, so the span there is positive.
  always_comb begin
    full3    = $signed({3'b0, mv2}) >= hi2;
    pos3     = {2'b0, mv2} > lo2;
    offs3    = mv2 - lo2[MV_W-1:0];
    den_full = hi2 - $signed({1'b0, lo2});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].rem  <= {{TRAVEL_W{1'b0}}, offs3} * NUM_W'(FULL_TRAVEL);
      st[0].quo  <= '0;
      st[0].den  <= den_full[DEN_W-1:0];
      st[0].mv   <= mv2;
      st[0].full <= full3;
      st[0].pos  <= pos3;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    localparam int B = DIV_STEPS - 1 - k;
    logic [NUM_W:0] trial;
    div_stage_t     step_next;
    assign trial = (NUM_W+1)'(st[k].den) << B;
    always_comb begin
      step_next = st[k];
      if ({1'b0, st[k].rem} >= trial) begin
        step_next.rem    = st[k].rem - trial[NUM_W-1:0];
        step_next.quo[B] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st[k+1] <= step_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_out.mv <= st[DIV_STEPS].mv;
      if (st[DIV_STEPS].full) begin
        lane_out.travel <= TRAVEL_W'(FULL_TRAVEL);
      end else if (st[DIV_STEPS].pos) begin
        lane_out.travel <= st[DIV_STEPS].quo;
      end else begin
        lane_out.travel <= '0;
      end
    end
  end

endmodule

// ===== hdl/dpsc_merge.sv =====
module dpsc_merge (
  input  logic                 clk,
  input  logic                 en,
  input  dpsc_pkg::lane_out_t  lane_one,
  input  dpsc_pkg::lane_out_t  lane_two,
  input  dpsc_pkg::cal_t       cal_one,
  input  dpsc_pkg::cal_t       cal_two,
  output dpsc_pkg::result_t    result
);
  import dpsc_pkg::*;

  logic [MV_W-1:0]     volt_gap;
  logic [TRAVEL_W-1:0] travel_gap;
  logic [TRAVEL_W:0]   travel_sum;
  logic                grounded;
  logic                powered;
  logic                too_close;
  logic                cal_fault;
  logic                mismatch;

  // The low limit is min - 100 in signed terms, so compare mv + 100 against min.
  function automatic logic out_of_cal(input logic [MV_W-1:0] mv, input cal_t cal);
    logic [REG_W:0] v;
    v = (REG_W+1)'(mv);
    return ((v + (REG_W+1)'(CAL_MARGIN_MV)) < {1'b0, cal.min_mv}) ||
           (v > ({1'b0, cal.max_mv} + (REG_W+1)'(CAL_MARGIN_MV)));
  endfunction

  always_comb begin
    volt_gap   = (lane_one.mv >= lane_two.mv) ? (lane_one.mv - lane_two.mv)
                                              : (lane_two.mv - lane_one.mv);
    travel_gap = (lane_one.travel >= lane_two.travel) ? (lane_one.travel - lane_two.travel)
                                                      : (lane_two.travel - lane_one.travel);
    travel_sum = {1'b0, lane_one.travel} + {1'b0, lane_two.travel};
    grounded   = (lane_one.mv < MV_W'(CH1_FLOOR_MV)) || (lane_two.mv < MV_W'(CH2_FLOOR_MV));
    powered    = ((REG_W+1)'(lane_one.mv) > (REG_W+1)'(CH1_CEIL_MV)) ||
                 (lane_two.mv > MV_W'(CH2_CEIL_MV));
    too_close  = volt_gap < MV_W'(MIN_SPLIT_MV);
    cal_fault  = out_of_cal(lane_one.mv, cal_one) || out_of_cal(lane_two.mv, cal_two);
    mismatch   = travel_gap > TRAVEL_W'(MAX_TRAVEL_GAP);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.volts_one_mv <= lane_one.mv;
      result.volts_two_mv <= lane_two.mv;
      result.travel_one   <= lane_one.travel;
      result.travel_two   <= lane_two.travel;
      result.pedal_travel <= travel_sum[TRAVEL_W:1];
      result.plausible    <= !(grounded || powered || too_close || cal_fault || mismatch);
    end
  end

endmodule

// ===== hdl/dual_pedal_sensor_position_check_top.sv =====
// Redundant pedal sensor check. Each item carries one raw 12-bit reading from each of
// two pedal sensors; the block returns one result per item with both voltages in
// millivolts, both travels in tenths of a percent, their floor average and a
// plausibility flag. One item is accepted every clock cycle unless the input is stalled;
// each item passes the lane setup stages and then the ten-stage restoring divider in each
// channel's lane that turns voltage into travel. A one-entry skid register behind the
// last stage lets the pipeline take a new item while a finished result waits; the input
// is stalled only while that register is occupied. Calibration registers are read
// directly by the pipeline, so they must be written while no item is in flight.
module dual_pedal_sensor_position_check_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            sample_valid,
  output logic                            sample_stall,
  input  dpsc_pkg::sample_t               sample,
  output logic                            result_valid,
  input  logic                            result_stall,
  output dpsc_pkg::result_t               result,
  input  logic                            cfg_we,
  input  logic [dpsc_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [dpsc_pkg::REG_W-1:0]      cfg_data
);
  import dpsc_pkg::*;

  cal_t                  cal_one;
  cal_t                  cal_two;
  logic                  en;
  logic [PIPE_DEPTH-1:0] vld;
  logic                  skid_full;
  result_t               skid;
  result_t               merged;
  lane_out_t             lane_one;
  lane_out_t             lane_two;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_one.min_mv <= CH1_MIN_RESET;
      cal_one.max_mv <= CH1_MAX_RESET;
      cal_two.min_mv <= CH2_MIN_RESET;
      cal_two.max_mv <= CH2_MAX_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_CH1_MIN: cal_one.min_mv <= cfg_data;
        REG_CH1_MAX: cal_one.max_mv <= cfg_data;
        REG_CH2_MIN: cal_two.min_mv <= cfg_data;
        REG_CH2_MAX: cal_two.max_mv <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together whenever the skid register is free.
  assign en           = !skid_full;
  assign sample_stall = skid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      skid_full <= 1'b0;
    end else begin
      if (en) begin
        vld <= {vld[PIPE_DEPTH-2:0], sample_valid};
      end
      if (en && vld[PIPE_DEPTH-1] && result_stall) begin
        skid_full <= 1'b1;
      end else if (skid_full && !result_stall) begin
        skid_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld[PIPE_DEPTH-1] && result_stall) begin
      skid <= merged;
    end
  end

  assign result_valid = skid_full || vld[PIPE_DEPTH-1];
  assign result       = skid_full ? skid : merged;

  dpsc_lane u_lane_one (
    .clk      (clk),
    .en       (en),
    .raw      (sample.sample_one),
    .cal      (cal_one),
    .lane_out (lane_one)
  );

  dpsc_lane u_lane_two (
    .clk      (clk),
    .en       (en),
    .raw      (sample.sample_two),
    .cal      (cal_two),
    .lane_out (lane_two)
  );

  dpsc_merge u_merge (
    .clk      (clk),
    .en       (en),
    .lane_one (lane_one),
    .lane_two (lane_two),
    .cal_one  (cal_one),
    .cal_two  (cal_two),
    .result   (merged)
  );

endmodule

// ===== hdl/dpsc_checker.sv =====
module dpsc_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_stall,
  input  logic               result_valid,
  input  logic               result_stall,
  input  dpsc_pkg::result_t  result
);
  import dpsc_pkg::*;

  // A held result stays offered.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  // A held result keeps its value.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result))
    else $error("result changed while stalled");

  // The input is only held back while a finished result is waiting.
  assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> result_valid)
    else $error("input stalled with no result pending");

  // The average and the plausibility flag agree with the two channel travels.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.pedal_travel ==
                      TRAVEL_W'(({1'b0, result.travel_one} + {1'b0, result.travel_two}) >> 1)) &&
                     (!result.plausible ||
                      (({1'b0, result.travel_one} <=
                        {1'b0, result.travel_two} + (TRAVEL_W+1)'(MAX_TRAVEL_GAP)) &&
                       ({1'b0, result.travel_two} <=
                        {1'b0, result.travel_one} + (TRAVEL_W+1)'(MAX_TRAVEL_GAP)))))
    else $error("result fields inconsistent");

endmodule

bind dual_pedal_sensor_position_check_top dpsc_checker u_dpsc_checker (.*);
